// ===== hw/rtl/prm_pkg.sv =====
`default_nettype none

package prm_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned RegIdxW = 8;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [FuncW-1:0] FUNC_PULSE = 2'd0;
  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_READ  = 2'd2;

  localparam logic [RegIdxW-1:0] REG_ADDR = 8'd0;
  localparam logic [RegIdxW-1:0] REG_CPM  = 8'd1;

  localparam logic [CfgIdxW-1:0] CFG_ADDR   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESH = 8'd1;

  localparam logic [AddrW-1:0] ADDR_RESET   = 7'h4D;
  localparam logic [DataW-1:0] THRESH_RESET = 16'd5;
  localparam logic [DataW-1:0] SAT16        = 16'hFFFF;

  // per-second count to counts per minute (times 60)
  localparam int unsigned MulW = DataW + 6;

endpackage

`default_nettype wire

// ===== hw/rtl/pulse_rate_meter_cpm_unit.sv =====
`default_nettype none

// Pulse-rate meter: every request gives one response. Requests are taken one per
// cycle while the response output is not stalled, and each response passes the
// ring read stage and then the update stage. One request per cycle is kept up
// because the ring of per-second counts has one read port and one write port: it
// is read when a tick request is taken and written back when that request leaves
// the read stage. Reset empties the ring at once through per-entry valid bits, so
// the block is ready right after reset. The ring is revisited only every WINDOW
// ticks, which keeps a tick's read clear of the previous tick's write.
module pulse_rate_meter_cpm_unit
  import prm_pkg::*;
#(
  parameter int unsigned WINDOW = 60
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [DataW-1:0]     cfg_wdata_i,
  // request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] reg_index
  input  wire logic [FuncW-1:0]     s_axis_tuser,   // [1:0] func
  // response stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [39:0]               m_axis_tdata    // [15:0] read_data, [31:16] cpm,
                                                    // [32] sum_mode, [33] led_on, zero pad
);

  localparam int unsigned PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TotW = DataW + PosW;
  localparam logic [PosW-1:0] PosLast = PosW'(WINDOW - 1);

  // configuration
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
      thr_q  <= THRESH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ADDR) begin
        addr_q <= cfg_wdata_i[AddrW-1:0];
      end else if (cfg_idx_i == CFG_THRESH) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // pipeline handshake
  logic s1_vld_q, out_vld_q;
  logic out_free, s1_adv, s_acc;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // ring of per-second counts
  logic [DataW-1:0]  ring_mem [WINDOW];
  logic [WINDOW-1:0] ring_vld_q;
  logic [PosW-1:0]   pos_q;
  logic [DataW-1:0]  rd_data_q;
  logic              rd_vld_q;
  logic [DataW-1:0]  pulse_q, pulse_d;

  logic [FuncW-1:0]   s1_func_q;
  logic [RegIdxW-1:0] s1_reg_q;
  logic [PosW-1:0]    s1_pos_q;

  logic s_tick, s1_tick;
  assign s_tick  = s_acc && (s_axis_tuser == FUNC_TICK);
  assign s1_tick = s1_adv && (s1_func_q == FUNC_TICK);

  // issue the ring read and advance the position when a tick is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (s_tick) begin
        pos_q <= (pos_q == PosLast) ? '0 : pos_q + 1'b1;
      end
      if (s_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_func_q <= s_axis_tuser;
      s1_reg_q  <= s_axis_tdata;
      s1_pos_q  <= pos_q;
    end
    if (s_tick) begin
      rd_data_q <= ring_mem[pos_q];
    end
    if (s1_tick) begin
      ring_mem[s1_pos_q] <= pulse_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (s_tick) begin
        rd_vld_q <= ring_vld_q[pos_q];
      end
      if (s1_tick) begin
        ring_vld_q[s1_pos_q] <= 1'b1;
      end
    end
  end

  // update stage
  logic [TotW-1:0]  total_q, total_d;
  logic [DataW-1:0] cpm_q, cpm_d;
  logic             slow_q, slow_d;
  logic             led_q, led_d;
  logic [DataW-1:0] rdat_d;
  logic [DataW-1:0] old_cnt;
  logic [MulW-1:0]  cps_x60;

  assign old_cnt = rd_vld_q ? rd_data_q : '0;
  assign cps_x60 = {pulse_q, 6'd0} - {4'd0, pulse_q, 2'd0};

  always_comb begin
    pulse_d = pulse_q;
    total_d = total_q;
    cpm_d   = cpm_q;
    slow_d  = slow_q;
    led_d   = led_q;
    rdat_d  = '0;
    case (s1_func_q)
      FUNC_PULSE: begin
        if (pulse_q != SAT16) begin
          pulse_d = pulse_q + 1'b1;
        end
        led_d = !led_q;
      end
      FUNC_TICK: begin
        pulse_d = '0;
        total_d = total_q - TotW'(old_cnt) + TotW'(pulse_q);
        if (pulse_q < thr_q) begin
          slow_d = 1'b1;
          cpm_d  = (total_d > TotW'(SAT16)) ? SAT16 : total_d[DataW-1:0];
        end else begin
          slow_d = 1'b0;
          cpm_d  = (cps_x60 > MulW'(SAT16)) ? SAT16 : cps_x60[DataW-1:0];
        end
      end
      FUNC_READ: begin
        if (s1_reg_q == REG_ADDR) begin
          rdat_d = DataW'(addr_q);
        end else if (s1_reg_q == REG_CPM) begin
          rdat_d = cpm_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q   <= '0;
      total_q   <= '0;
      cpm_q     <= '0;
      slow_q    <= 1'b0;
      led_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        pulse_q <= pulse_d;
        total_q <= total_d;
        cpm_q   <= cpm_d;
        slow_q  <= slow_d;
        led_q   <= led_d;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // hold the response until it is taken
  logic [DataW-1:0] out_rd_q, out_cpm_q;
  logic             out_slow_q, out_led_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_rd_q   <= rdat_d;
      out_cpm_q  <= cpm_d;
      out_slow_q <= slow_d;
      out_led_q  <= led_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_led_q, out_slow_q, out_cpm_q, out_rd_q};

endmodule

`default_nettype wire

// ===== bench/pulse_rate_meter_cpm_unit_tb.sv =====
`default_nettype none

module pulse_rate_meter_cpm_unit_tb;
  import prm_pkg::*;

  localparam int unsigned RING_LEN     = 60;
  localparam int unsigned CPM_SCALE    = 60;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam int unsigned CLIP_PULSES  = 1100;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT  = 2000;

  localparam logic [FuncW-1:0]   FUNC_NONE   = 2'd3;
  localparam logic [RegIdxW-1:0] REG_NONE_LO = 8'd2;
  localparam logic [RegIdxW-1:0] REG_NONE_HI = 8'hFF;
  localparam logic [CfgIdxW-1:0] CFG_NONE_LO = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_NONE_HI = 8'hFF;

  typedef struct packed {
    logic              led_on;
    logic              sum_mode;
    logic [DataW-1:0]  cpm;
    logic [DataW-1:0]  read_data;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [DataW-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [7:0] reg_index
  logic [FuncW-1:0]     s_axis_tuser = '0;   // [1:0] func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;        // [15:0] read_data, [31:16] cpm,
                                             // [32] sum_mode, [33] led_on

  pulse_rate_meter_cpm_unit #(
    .WINDOW(RING_LEN)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial forever #5 clk_i = ~clk_i;

  // Meter state as the block should hold it
  logic [AddrW-1:0]  addr_q = ADDR_RESET;
  logic [DataW-1:0]  thresh_q = THRESH_RESET;
  logic [DataW-1:0]  pulse_cnt = '0;
  logic [DataW-1:0]  ring [RING_LEN] = '{default: '0};
  int unsigned       ring_pos = 0;
  int unsigned       ring_total = 0;
  logic [DataW-1:0]  cpm_q = '0;
  logic              slow_q = 1'b0;
  logic              led_q = 1'b0;

  reading_t          pending_readings [$];

  int unsigned n_items = 0, n_pulse = 0, n_tick = 0, n_read = 0, n_noise = 0;
  int unsigned n_slow = 0, n_fast = 0, n_clip = 0, n_errors = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [DataW-1:0] clip16(input int unsigned v);
    return (v > int'(SAT16)) ? SAT16 : v[DataW-1:0];
  endfunction

  task automatic advance_meter(input logic [FuncW-1:0] fn, input logic [RegIdxW-1:0] idx);
    reading_t    r;
    int unsigned cps;
    r.read_data = '0;
    n_items++;
    case (fn)
      FUNC_PULSE: begin
        if (pulse_cnt != SAT16) pulse_cnt++;
        led_q = ~led_q;
        n_pulse++;
      end
      FUNC_TICK: begin
        cps = 32'(pulse_cnt);
        pulse_cnt = '0;
        ring_total = ring_total - ring[ring_pos] + cps;
        ring[ring_pos] = cps[DataW-1:0];
        ring_pos = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
        if (cps < thresh_q) begin
          slow_q = 1'b1;
          cpm_q = clip16(ring_total);
          n_slow++;
        end else begin
          slow_q = 1'b0;
          cpm_q = clip16(cps * CPM_SCALE);
          n_fast++;
        end
        if (cpm_q == SAT16) n_clip++;
        n_tick++;
      end
      FUNC_READ: begin
        if (idx == REG_ADDR) r.read_data = {{(DataW-AddrW){1'b0}}, addr_q};
        else if (idx == REG_CPM) r.read_data = cpm_q;
        n_read++;
      end
      default: n_noise++;
    endcase
    r.cpm = cpm_q;
    r.sum_mode = slow_q;
    r.led_on = led_q;
    pending_readings.push_back(r);
  endtask

  // Send one request; open a gap before a new burst now and then
  task automatic issue_request(input logic [FuncW-1:0] fn, input logic [RegIdxW-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= idx;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    advance_meter(fn, idx);
    @(posedge clk_i);
  endtask

  // Hold requests until every response is back, then let the pipeline settle
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_ADDR) addr_q = val[AddrW-1:0];
    else if (idx == CFG_THRESH) thresh_q = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: segments of always-ready, coin-flip, sparse and periodic acceptance
  int unsigned rx_mode = 0, rx_left = 0, rx_phase = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_phase = (rx_phase == 4) ? 0 : rx_phase + 1;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_phase < 2);
    endcase
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  reading_t want_r;
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected response: expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want_r = pending_readings.pop_front();
        check_field("read_data", 32'(want_r.read_data), 32'(m_axis_tdata[15:0]));
        check_field("cpm", 32'(want_r.cpm), 32'(m_axis_tdata[31:16]));
        check_field("sum_mode", 32'(want_r.sum_mode), 32'(m_axis_tdata[32]));
        check_field("led_on", 32'(want_r.led_on), 32'(m_axis_tdata[33]));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_reset_and_ops();
    issue_request(FUNC_READ, REG_ADDR);
    issue_request(FUNC_READ, REG_CPM);
    issue_request(FUNC_READ, REG_NONE_LO);
    issue_request(FUNC_READ, REG_NONE_HI);
    issue_request(FUNC_NONE, REG_NONE_HI);
    // empty second right after reset: ring must read back as cleared
    issue_request(FUNC_TICK, 8'hAA);
    repeat (6) issue_request(FUNC_PULSE, 8'h55);
    issue_request(FUNC_TICK, 8'hFF);
    issue_request(FUNC_READ, REG_CPM);
    repeat (4) issue_request(FUNC_PULSE, 8'hAA);
    issue_request(FUNC_TICK, 8'h00);
    issue_request(FUNC_READ, REG_CPM);
    issue_request(FUNC_NONE, 8'h00);
    settle_block();
    // writes outside the register list must be dropped; upper bits masked off
    write_reg(CFG_NONE_LO, 16'hFFFF);
    write_reg(CFG_NONE_HI, 16'hFFFF);
    write_reg(CFG_ADDR, 16'hFF88);
    write_reg(CFG_THRESH, 16'h0000);
    issue_request(FUNC_READ, REG_ADDR);
    issue_request(FUNC_TICK, 8'h0F);
    issue_request(FUNC_READ, REG_CPM);
    settle_block();
    write_reg(CFG_ADDR, 16'hFFF7);
    write_reg(CFG_THRESH, SAT16);
    issue_request(FUNC_PULSE, 8'hF0);
    issue_request(FUNC_TICK, 8'h3C);
    issue_request(FUNC_READ, REG_ADDR);
    issue_request(FUNC_READ, REG_CPM);
  endtask

  task automatic test_threshold_sweep();
    int unsigned      start, base, n, pick;
    logic [DataW-1:0] thr;
    logic [AddrW-1:0] addr;
    logic [RegIdxW-1:0] ridx;
    for (int ph = 0; ph < 6; ph++) begin
      settle_block();
      case (ph)
        0: begin thr = 16'd1; addr = 7'd8; end
        1: begin thr = SAT16; addr = 7'd119; end
        2: begin thr = '0; addr = 7'($urandom_range(8, 119)); end
        3: begin thr = 16'd12; addr = 7'($urandom_range(8, 119)); end
        4: begin thr = 16'($urandom_range(2, 30)); addr = 7'($urandom_range(8, 119)); end
        default: begin thr = THRESH_RESET; addr = ADDR_RESET; end
      endcase
      write_reg(CFG_ADDR, {{(DataW-AddrW){1'b0}}, addr});
      write_reg(CFG_THRESH, thr);
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        // pulses per second cluster around the threshold to hit both modes
        base = (thresh_q > 40) ? $urandom_range(0, 40) : 32'(thresh_q);
        case ($urandom_range(0, 3))
          0: n = 0;
          1: n = (base == 0) ? $urandom_range(0, 1) : base - 1 + $urandom_range(0, 2);
          default: n = $urandom_range(0, 40);
        endcase
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            case ($urandom_range(0, 3))
              0: ridx = REG_ADDR;
              1: ridx = REG_CPM;
              default: ridx = 8'($urandom);
            endcase
            issue_request(FUNC_READ, ridx);
          end else if (pick < 11) begin
            issue_request(FUNC_NONE, 8'($urandom));
          end
          issue_request(FUNC_PULSE, 8'($urandom));
        end
        issue_request(FUNC_TICK, 8'($urandom));
        if ($urandom_range(0, 3) == 0) issue_request(FUNC_READ, REG_CPM);
        if ($urandom_range(0, 19) == 0) settle_block();
      end
    end
  endtask

  task automatic test_saturation();
    settle_block();
    write_reg(CFG_THRESH, THRESH_RESET);
    // enough pulses in one second that the scaled rate runs past full scale
    repeat (CLIP_PULSES) issue_request(FUNC_PULSE, 8'($urandom));
    issue_request(FUNC_READ, REG_CPM);
    issue_request(FUNC_TICK, 8'($urandom));
    issue_request(FUNC_READ, REG_CPM);
    settle_block();
    // carry the large entry once around the ring in window-sum mode
    write_reg(CFG_THRESH, SAT16);
    repeat (RING_LEN + 2) begin
      issue_request(FUNC_PULSE, 8'($urandom));
      issue_request(FUNC_TICK, 8'($urandom));
      issue_request(FUNC_READ, REG_CPM);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_ops();
    test_threshold_sweep();
    test_saturation();
    settle_block();
    $display("Covered %0d requests: %0d pulses, %0d reads, %0d unknown functions, %0d ticks",
             n_items, n_pulse, n_read, n_noise, n_tick);
    $display("Ticks in window-sum mode %0d, scaled mode %0d, clipped at full scale %0d; errors %0d",
             n_slow, n_fast, n_clip, n_errors);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
